### design/rbst_pkg.sv
// Package for the ray/box slab test: payload structs and float compare helpers.
// No dependencies.
package rbst_pkg;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam int NUM_REGS = 8;

  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_INV_DIR_X = 3'd3;
  localparam logic [2:0] REG_T_MIN     = 3'd6;
  localparam logic [2:0] REG_T_MAX     = 3'd7;

  typedef struct packed {
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_min_z;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
    logic [31:0] box_max_z;
  } box_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] entry_distance;
  } result_t;

  function automatic logic is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_zero(input logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  // a < b, false when either is NaN
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  function automatic logic flt_le(input logic [31:0] a, input logic [31:0] b);
    logic eq;
    eq = !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
    return eq || flt_lt(a, b);
  endfunction

  // compares below zero: -0 and NaN excluded
  function automatic logic flt_neg(input logic [31:0] a);
    return a[31] && !is_zero(a) && !is_nan(a);
  endfunction

endpackage

### design/rbst_fsub.sv
// Two-stage single precision subtractor y = a - b, round to nearest even.
// Uses rbst_pkg for NaN detection.
module rbst_fsub (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

  // stage A: specials, swap, align, add
  logic        sa, sb, inf_a, inf_b, eff_sub, a_big;
  logic [7:0]  xa, xb, xbig, xsml, dexp;
  logic [23:0] ma, mb, mbig, msml;
  logic        sbig;
  logic [4:0]  dcap;
  logic [53:0] shifted;
  logic [26:0] sml27;
  logic [27:0] sum;
  logic        spec_d, spec_q, zsgn_d, zsgn_q, sgn_q;
  logic [31:0] specv_d, specv_q;
  logic [27:0] sum_q;
  logic [7:0]  x_q;

  always_comb begin
    sa    = a_i[31];
    sb    = ~b_i[31];
    inf_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    spec_d  = 1'b1;
    specv_d = rbst_pkg::CANON_NAN;
    if (rbst_pkg::is_nan(a_i) || rbst_pkg::is_nan(b_i)) begin
      specv_d = rbst_pkg::CANON_NAN;
    end else if (inf_a && inf_b) begin
      specv_d = (sa != sb) ? rbst_pkg::CANON_NAN : {sa, 8'hFF, 23'd0};
    end else if (inf_a) begin
      specv_d = {sa, 8'hFF, 23'd0};
    end else if (inf_b) begin
      specv_d = {sb, 8'hFF, 23'd0};
    end else begin
      spec_d = 1'b0;
    end
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    xa = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    xb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    a_big = {xa, ma} >= {xb, mb};
    xbig = a_big ? xa : xb;
    mbig = a_big ? ma : mb;
    sbig = a_big ? sa : sb;
    xsml = a_big ? xb : xa;
    msml = a_big ? mb : ma;
    dexp = xbig - xsml;
    dcap = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
    shifted = {msml, 3'b000, 27'd0} >> dcap;
    sml27 = {shifted[53:28], shifted[27] | (|shifted[26:0])};
    eff_sub = sa ^ sb;
    sum = eff_sub ? ({1'b0, mbig, 3'b000} - {1'b0, sml27})
                  : ({1'b0, mbig, 3'b000} + {1'b0, sml27});
    zsgn_d = eff_sub ? 1'b0 : sbig;
  end

  always_ff @(posedge clk_i) begin
    spec_q  <= spec_d;
    specv_q <= specv_d;
    sum_q   <= sum;
    x_q     <= xbig;
    sgn_q   <= sbig;
    zsgn_q  <= zsgn_d;
  end

  // stage B: normalize and round
  logic [26:0] nrm;
  logic [8:0]  e;
  logic [4:0]  lz, sh;
  logic [7:0]  ef;
  logic        rnd;
  logic [30:0] packed_v;
  logic [31:0] y_d;

  always_comb begin
    lz = lzc27(sum_q[26:0]);
    sh = 5'd0;
    if (sum_q[27]) begin
      nrm = {sum_q[27:2], |sum_q[1:0]};
      e   = {1'b0, x_q} + 9'd1;
    end else begin
      sh  = ({3'b000, lz} < x_q) ? lz : 5'(x_q - 8'd1);
      nrm = sum_q[26:0] << sh;
      e   = {1'b0, x_q} - {4'd0, sh};
    end
    ef  = nrm[26] ? e[7:0] : 8'd0;
    rnd = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    packed_v = {ef, nrm[25:3]} + {30'd0, rnd};
    if (spec_q) begin
      y_d = specv_q;
    end else if (sum_q == 28'd0) begin
      y_d = {zsgn_q, 31'd0};
    end else if (e >= 9'd255) begin
      y_d = {sgn_q, 8'hFF, 23'd0};
    end else begin
      y_d = {sgn_q, packed_v};
    end
  end

  always_ff @(posedge clk_i) begin
    y_o <= y_d;
  end

endmodule

### design/rbst_fmul.sv
// Two-stage single precision multiplier, round to nearest even, subnormals kept.
// Uses rbst_pkg for NaN and zero detection.
module rbst_fmul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] y_o
);

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // stage A: specials and mantissa product
  logic        inf_a, inf_b, spec_d, spec_q, sgn_d, sgn_q;
  logic [31:0] specv_d, specv_q;
  logic [23:0] ma, mb;
  logic [7:0]  xa, xb;
  logic [47:0] prod_q;
  logic [8:0]  esum_q;

  always_comb begin
    sgn_d = a_i[31] ^ b_i[31];
    inf_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    inf_b = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    spec_d  = 1'b1;
    specv_d = rbst_pkg::CANON_NAN;
    if (rbst_pkg::is_nan(a_i) || rbst_pkg::is_nan(b_i)) begin
      specv_d = rbst_pkg::CANON_NAN;
    end else if ((inf_a && rbst_pkg::is_zero(b_i)) || (inf_b && rbst_pkg::is_zero(a_i))) begin
      specv_d = rbst_pkg::CANON_NAN;
    end else if (inf_a || inf_b) begin
      specv_d = {sgn_d, 8'hFF, 23'd0};
    end else if (rbst_pkg::is_zero(a_i) || rbst_pkg::is_zero(b_i)) begin
      specv_d = {sgn_d, 31'd0};
    end else begin
      spec_d = 1'b0;
    end
    ma = {a_i[30:23] != 8'd0, a_i[22:0]};
    mb = {b_i[30:23] != 8'd0, b_i[22:0]};
    xa = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    xb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
  end

  always_ff @(posedge clk_i) begin
    spec_q  <= spec_d;
    specv_q <= specv_d;
    sgn_q   <= sgn_d;
    prod_q  <= ma * mb;
    esum_q  <= {1'b0, xa} + {1'b0, xb};
  end

  // stage B: normalize (with underflow shift) and round
  logic [5:0]         lz;
  logic signed [11:0] e, t;
  logic [5:0]         rs;
  logic [95:0]        wide;
  logic [47:0]        nrm;
  logic [7:0]         ef;
  logic               rnd;
  logic [30:0]        packed_v;
  logic [31:0]        y_d;

  always_comb begin
    lz   = lzc48(prod_q);
    e    = $signed({3'b000, esum_q}) - 12'sd126 - $signed({6'd0, lz});
    t    = $signed({6'd0, lz}) + e - 12'sd1;
    rs   = 6'd0;
    wide = 96'd0;
    if (e >= 12'sd1) begin
      nrm = prod_q << lz;
    end else if (t >= 12'sd0) begin
      nrm = prod_q << t[5:0];
    end else begin
      rs   = (t < -12'sd48) ? 6'd48 : 6'(-t);
      wide = {prod_q, 48'd0} >> rs;
      nrm  = {wide[95:49], wide[48] | (|wide[47:0])};
    end
    ef  = nrm[47] ? e[7:0] : 8'd0;
    rnd = nrm[23] & ((|nrm[22:0]) | nrm[24]);
    packed_v = {ef, nrm[46:24]} + {30'd0, rnd};
    if (spec_q) begin
      y_d = specv_q;
    end else if (e >= 12'sd255) begin
      y_d = {sgn_q, 8'hFF, 23'd0};
    end else begin
      y_d = {sgn_q, packed_v};
    end
  end

  always_ff @(posedge clk_i) begin
    y_o <= y_d;
  end

endmodule

### design/ray_box_slab_test_core.sv
// Ray/box slab test core: six subtract/multiply lanes, slab fold, hit compare.
// Depends on rbst_pkg, rbst_fsub, rbst_fmul.
// Throughput: one box per cycle, always.
// Pipeline: 2 subtract stages, 2 multiply stages, fold stage, compare/output stage.
// busy_o is never raised; the result strobe cannot be stalled.
// Reset clears the ray registers to +0.0 and the pipeline valid bits.
module ray_box_slab_test_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rbst_pkg::box_t   box_i,
  output logic             busy_o,
  output logic             valid_o,
  output rbst_pkg::result_t result_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_data_i
);

  logic [31:0] regs_q [rbst_pkg::NUM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rbst_pkg::NUM_REGS; i++) regs_q[i] <= 32'd0;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign busy_o = 1'b0;

  logic [5:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 6'd0;
    end else begin
      vld_q <= {vld_q[4:0], start_i};
    end
  end

  // lanes 0..2 take the min corner, 3..5 the max corner
  logic [31:0] bound [6];
  logic [31:0] diff  [6];
  logic [31:0] tval  [6];
  assign bound[0] = box_i.box_min_x;
  assign bound[1] = box_i.box_min_y;
  assign bound[2] = box_i.box_min_z;
  assign bound[3] = box_i.box_max_x;
  assign bound[4] = box_i.box_max_y;
  assign bound[5] = box_i.box_max_z;

  for (genvar g = 0; g < 6; g++) begin : g_lane
    localparam logic [2:0] Axis = 3'(g % 3);
    rbst_fsub u_sub (
      .clk_i (clk_i),
      .a_i   (bound[g]),
      .b_i   (regs_q[rbst_pkg::REG_ORIGIN_X + Axis]),
      .y_o   (diff[g])
    );
    rbst_fmul u_mul (
      .clk_i (clk_i),
      .a_i   (diff[g]),
      .b_i   (regs_q[rbst_pkg::REG_INV_DIR_X + Axis]),
      .y_o   (tval[g])
    );
  end

  // fold in order x, y, z, then the t bound
  logic [31:0] tn [3];
  logic [31:0] tf [3];
  logic [31:0] ent_d, ext_d, ent_q, ext_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (rbst_pkg::flt_neg(regs_q[rbst_pkg::REG_INV_DIR_X + 3'(a)])) begin
        tn[a] = tval[a + 3];
        tf[a] = tval[a];
      end else begin
        tn[a] = tval[a];
        tf[a] = tval[a + 3];
      end
    end
    ent_d = tn[0];
    ext_d = tf[0];
    for (int a = 1; a < 3; a++) begin
      if (rbst_pkg::flt_lt(ent_d, tn[a])) ent_d = tn[a];
      if (rbst_pkg::flt_lt(tf[a], ext_d)) ext_d = tf[a];
    end
    if (rbst_pkg::flt_lt(ent_d, regs_q[rbst_pkg::REG_T_MIN])) ent_d = regs_q[rbst_pkg::REG_T_MIN];
    if (rbst_pkg::flt_lt(regs_q[rbst_pkg::REG_T_MAX], ext_d)) ext_d = regs_q[rbst_pkg::REG_T_MAX];
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    ext_q <= ext_d;
  end

  rbst_pkg::result_t res_d, res_q;
  always_comb begin
    res_d.hit            = rbst_pkg::flt_le(ent_q, ext_q);
    res_d.entry_distance = rbst_pkg::is_nan(ent_q) ? rbst_pkg::CANON_NAN : ent_q;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vld_q[5];
  assign result_o = res_q;

  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##6 valid_o) else $error("accepted item lost");
  a_noinv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##6 !valid_o) else $error("result strobe without item");
  a_nanhit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.hit) |-> (result_o.entry_distance != rbst_pkg::CANON_NAN))
    else $error("hit reported with NaN entry");

endmodule

### tb/sv/ray_box_slab_test_core_tb.sv
// Self-checking testbench for ray_box_slab_test_core: random and directed boxes
// against a bit-exact single-precision slab predictor. Depends on rbst_pkg.
module ray_box_slab_test_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_INF = 32'hFF80_0000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  rbst_pkg::box_t    box_i = '0;
  logic              busy_o, valid_o;
  rbst_pkg::result_t result_o;
  logic              cfg_we_i = 1'b0;
  logic [2:0]        cfg_idx_i = '0;
  logic [31:0]       cfg_data_i = '0;

  ray_box_slab_test_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .box_i(box_i),
    .busy_o(busy_o), .valid_o(valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  logic [31:0]       ray_reg [rbst_pkg::NUM_REGS];
  rbst_pkg::box_t    box_q [$];
  rbst_pkg::result_t hit_q [$];
  int                fails = 0;
  int                cycles = 0;
  bit                no_gaps = 1'b0;

  // ---------------- single-precision arithmetic ----------------
  function automatic logic f_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic logic [31:0] round_pack(logic s, longint e, logic [26:0] m);
    logic [24:0] mant;
    logic up;
    mant = {1'b0, m[26:3]};
    up = m[2] && ((m[1:0] != 0) || m[3]);
    mant = mant + up;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (e >= 255) return {s, 8'hFF, 23'd0};
    return {s, (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    longint ea, eb, d;
    logic [63:0] xa, yb, sum;
    if (f_nan(a) || f_nan(b)) return rbst_pkg::CANON_NAN;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF)
      return (a[31] != b[31]) ? rbst_pkg::CANON_NAN : a;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (b[30:0] == 0) return a;
    if (a[30:0] == 0) return b;
    if (b[30:0] > a[30:0]) begin
      t = a; a = b; b = t;
    end
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    xa = {40'd0, a[30:23] != 0, a[22:0]} << 3;
    yb = {40'd0, b[30:23] != 0, b[22:0]} << 3;
    d = ea - eb;
    if (d > 27) yb = 1;
    else if (d > 0) yb = (yb >> d) | ((yb & ((64'd1 << d) - 1)) != 0);
    sum = (a[31] == b[31]) ? xa + yb : xa - yb;
    if (sum == 0) return 32'd0;
    if (sum[27]) begin
      sum = (sum >> 1) | sum[0];
      ea++;
    end
    while (!sum[26] && ea > 1) begin
      sum = sum << 1;
      ea--;
    end
    return round_pack(a[31], ea, sum[26:0]);
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic s;
    longint e, big_e, sh;
    logic [63:0] p, m;
    int lead;
    s = a[31] ^ b[31];
    if (f_nan(a) || f_nan(b)) return rbst_pkg::CANON_NAN;
    if ((a[30:23] == 8'hFF && b[30:0] == 0) || (b[30:23] == 8'hFF && a[30:0] == 0))
      return rbst_pkg::CANON_NAN;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
    if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
    e = ((a[30:23] == 0) ? 1 : a[30:23]) + ((b[30:23] == 0) ? 1 : b[30:23]) - 127;
    p = {40'd0, a[30:23] != 0, a[22:0]} * {40'd0, b[30:23] != 0, b[22:0]};
    lead = 0;
    for (int i = 0; i < 48; i++) if (p[i]) lead = i;
    big_e = e + lead - 46;
    sh = lead - 26;
    if (big_e < 1) begin
      sh += 1 - big_e;
      big_e = 1;
    end
    if (sh >= 64) m = (p != 0);
    else if (sh > 0) m = (p >> sh) | ((p & ((64'd1 << sh) - 1)) != 0);
    else m = p << (-sh);
    return round_pack(s, big_e, m[26:0]);
  endfunction

  // strict less-than; false when either side is NaN
  function automatic logic f_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka, kb;
    if (f_nan(a) || f_nan(b)) return 1'b0;
    ka = (a[30:0] == 0) ? 32'h8000_0000 : (a[31] ? ~a : (a | 32'h8000_0000));
    kb = (b[30:0] == 0) ? 32'h8000_0000 : (b[31] ? ~b : (b | 32'h8000_0000));
    return ka < kb;
  endfunction

  function automatic rbst_pkg::result_t slab_hit(rbst_pkg::box_t bx);
    logic [31:0] lo [3], hi [3];
    logic [31:0] tlo, thi, tn, tf, entry, exit_t, org, rdir;
    rbst_pkg::result_t r;
    lo[0] = bx.box_min_x; lo[1] = bx.box_min_y; lo[2] = bx.box_min_z;
    hi[0] = bx.box_max_x; hi[1] = bx.box_max_y; hi[2] = bx.box_max_z;
    entry = '0;
    exit_t = '0;
    for (int ax = 0; ax < 3; ax++) begin
      org  = ray_reg[rbst_pkg::REG_ORIGIN_X + ax];
      rdir = ray_reg[rbst_pkg::REG_INV_DIR_X + ax];
      tlo = f_mul(f_add(lo[ax], org ^ 32'h8000_0000), rdir);
      thi = f_mul(f_add(hi[ax], org ^ 32'h8000_0000), rdir);
      if (f_lt(rdir, 32'd0)) begin
        tn = thi; tf = tlo;
      end else begin
        tn = tlo; tf = thi;
      end
      if (ax == 0) begin
        entry = tn; exit_t = tf;
      end else begin
        if (f_lt(entry, tn)) entry = tn;
        if (f_lt(tf, exit_t)) exit_t = tf;
      end
    end
    if (f_lt(entry, ray_reg[rbst_pkg::REG_T_MIN])) entry = ray_reg[rbst_pkg::REG_T_MIN];
    if (f_lt(ray_reg[rbst_pkg::REG_T_MAX], exit_t)) exit_t = ray_reg[rbst_pkg::REG_T_MAX];
    r.hit = !f_nan(entry) && !f_nan(exit_t) && !f_lt(exit_t, entry);
    r.entry_distance = f_nan(entry) ? rbst_pkg::CANON_NAN : entry;
    return r;
  endfunction

  // ---------------- value generators ----------------
  function automatic logic [31:0] nice_f();
    return {1'($urandom_range(0, 1)), 8'($urandom_range(118, 136)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] odd_f();
    logic [31:0] specials [12] = '{32'h0, 32'h8000_0000, POS_INF, NEG_INF,
      rbst_pkg::CANON_NAN, 32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
      32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h3F80_0000};
    return specials[$urandom_range(0, 11)];
  endfunction

  function automatic logic [31:0] any_f();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return $urandom;
    if (k < 7) return odd_f();
    return nice_f();
  endfunction

  function automatic rbst_pkg::box_t sane_box();
    logic [31:0] a, b, lo [3], hi [3];
    rbst_pkg::box_t bx;
    for (int ax = 0; ax < 3; ax++) begin
      a = nice_f();
      b = nice_f();
      lo[ax] = f_lt(b, a) ? b : a;
      hi[ax] = f_lt(b, a) ? a : b;
    end
    bx = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    return bx;
  endfunction

  function automatic rbst_pkg::box_t wild_box();
    rbst_pkg::box_t bx;
    bx = '{any_f(), any_f(), any_f(), any_f(), any_f(), any_f()};
    return bx;
  endfunction

  task automatic add_box(rbst_pkg::box_t bx);
    box_q = {box_q, bx};
  endtask

  // ---------------- driver ----------------
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      gap = 0;
    end else begin
      if (start_i && !busy_o) hit_q = {hit_q, slab_hit(box_i)};
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        start_i <= 1'b0;
      end else if (box_q.size() > 0) begin
        box_i <= box_q[0];
        box_q.delete(0);
        start_i <= 1'b1;
        if (!no_gaps) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: gap = 0;
            6, 7, 8: gap = $urandom_range(1, 3);
            default: gap = $urandom_range(5, 40);
          endcase
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    rbst_pkg::result_t want;
    if (rst_ni && valid_o) begin
      if (hit_q.size() == 0) begin
        $display("%0t: unexpected result hit=%0b dist=%h", $realtime,
                 result_o.hit, result_o.entry_distance);
        fails++;
      end else begin
        want = hit_q[0];
        hit_q.delete(0);
        if (result_o.hit !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $realtime, want.hit, result_o.hit);
          fails++;
        end
        if (result_o.entry_distance !== want.entry_distance) begin
          $display("%0t: entry_distance expected %h actual %h", $realtime,
                   want.entry_distance, result_o.entry_distance);
          fails++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_box_slab_test_core_tb failed");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  task automatic write_reg(int idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'(idx);
    cfg_data_i <= val;
    ray_reg[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic load_ray(logic [31:0] o, logic [31:0] d, logic [31:0] tmin,
                          logic [31:0] tmax, bit wild);
    for (int i = 0; i < 3; i++) write_reg(rbst_pkg::REG_ORIGIN_X + i, wild ? any_f() : o);
    for (int i = 0; i < 3; i++) write_reg(rbst_pkg::REG_INV_DIR_X + i, wild ? any_f() : d);
    write_reg(rbst_pkg::REG_T_MIN, tmin);
    write_reg(rbst_pkg::REG_T_MAX, tmax);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (box_q.size() > 0 || hit_q.size() > 0 || start_i) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic fill(int n, int sane_pct);
    for (int i = 0; i < n; i++)
      add_box(($urandom_range(0, 99) < sane_pct) ? sane_box() : wild_box());
  endtask

  initial begin
    for (int i = 0; i < rbst_pkg::NUM_REGS; i++) ray_reg[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed boxes on the reset ray: zeros, signed zeros, infinities, NaN,
    // subnormals, largest finite values, all-ones and an inverted box
    no_gaps = 1'b1;
    add_box('0);
    add_box({6{32'hFFFF_FFFF}});
    add_box({6{32'h8000_0000}});
    add_box({{3{NEG_INF}}, {3{POS_INF}}});
    add_box({{3{32'h0000_0001}}, {3{32'h807F_FFFF}}});
    add_box({{3{32'hFF7F_FFFF}}, {3{32'h7F7F_FFFF}}});
    drain();

    // origin at zero, mixed reciprocal signs including negative zero
    write_reg(rbst_pkg::REG_ORIGIN_X, 32'h0);
    write_reg(rbst_pkg::REG_ORIGIN_X + 1, 32'h0);
    write_reg(rbst_pkg::REG_ORIGIN_X + 2, 32'h0);
    write_reg(rbst_pkg::REG_INV_DIR_X, 32'h3F80_0000);
    write_reg(rbst_pkg::REG_INV_DIR_X + 1, 32'hBF80_0000);
    write_reg(rbst_pkg::REG_INV_DIR_X + 2, 32'h8000_0000);
    write_reg(rbst_pkg::REG_T_MIN, 32'h0); write_reg(rbst_pkg::REG_T_MAX, POS_INF);
    cfg_we_i <= 1'b0;
    add_box({32'h3F80_0000, 32'hC000_0000, 32'hBF80_0000,
             32'h4000_0000, 32'hBF80_0000, 32'h3F80_0000});
    add_box({32'h4000_0000, 32'hC000_0000, 32'hBF80_0000,
             32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000});
    add_box({rbst_pkg::CANON_NAN, 32'h0, 32'h0,
             32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
    add_box({32'h0, rbst_pkg::CANON_NAN, 32'h0,
             32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
    add_box({32'h7F7F_FFFF, 32'h0, 32'h0, POS_INF, 32'h0, 32'h0});
    add_box({32'h0000_0001, 32'h0, 32'h0, 32'h0000_0002, 32'h0, 32'h0});
    drain();

    // every register NaN, then extremes of the ray
    load_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    fill(8, 50);
    drain();
    load_ray(32'h7F7F_FFFF, POS_INF, NEG_INF, POS_INF, 1'b0);
    fill(8, 50);
    drain();
    load_ray(32'hFF7F_FFFF, NEG_INF, POS_INF, NEG_INF, 1'b0);
    fill(40, 50);
    drain();

    // random rays, mostly well-formed boxes
    for (int ph = 0; ph < 10; ph++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      load_ray(nice_f(), nice_f(), ($urandom_range(0, 1) ? 32'h0 : nice_f()),
               ($urandom_range(0, 1) ? POS_INF : nice_f()), (ph == 3 || ph == 7));
      // mix reciprocal signs per axis
      for (int i = 0; i < 3; i++) write_reg(rbst_pkg::REG_INV_DIR_X + i, nice_f());
      cfg_we_i <= 1'b0;
      fill(150, 80);
      drain();
    end

    if (fails == 0) begin
      $display("ray_box_slab_test_core_tb passed");
    end else begin
      $display("ray_box_slab_test_core_tb failed");
    end
    $finish;
  end

endmodule
